@@ rtl/lrukv_pkg.sv @@
// Shared types, constants and sequencer states for the LRU key-value cache.
package lrukv_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEF_CAPACITY   = 8;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	// Operation codes of the func field
	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	// Command fields of one transfer into the cache
	typedef struct packed {
		logic               func;
		logic signed [31:0] lookup_key;
		logic signed [31:0] write_value;
	} cmd_t;

	// Result fields of one transfer out of the cache
	typedef struct packed {
		logic               found;
		logic signed [31:0] read_value;
		logic               evicted;
	} result_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RANK,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
// Usage:
//   A command (put or get, key, value) is transferred in at a rising edge
//   where start is high and busy is low. busy stays high while the command
//   is worked on. Its result (found, read_value, evicted) appears on result
//   for exactly one cycle with done high; the receiver cannot stall it and
//   must take it in that cycle.
//   Walk: one key comparator walks the CAPACITY stored entries, one per
//   cycle, through the registered memory read; then the same entry walk
//   updates the recency ranks through the rank memory port. A put or a
//   get hit walks the ranks, writes, then shows done; a get miss skips
//   the rank walk and goes from the decision straight to done. busy
//   drops in the done cycle, so a new command can be taken there.
//   Reset: arst_n clears the sequencer, the valid bits and the fill count,
//   so the cache starts empty; stored keys, values and ranks need no
//   clearing since only valid entries are ever looked at.
module lru_key_value_cache #(
	parameter int CAPACITY   = lrukv_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = lrukv_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lrukv_pkg::cmd_t     cmd,
	output logic                done,
	output lrukv_pkg::result_t  result
);

	localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int RANK_BITS = IDX_BITS;

	lrukv_pkg::state_t state_q, state_d;

	// Command registers
	logic                  func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// Walk counter and read pipeline stage
	logic [CNT_BITS-1:0] cnt_q;
	logic                issue;
	logic                v_s1;
	logic [IDX_BITS-1:0] idx_s1;

	// Scan results
	logic                 hit_q;
	logic [IDX_BITS-1:0]  hit_slot_q;
	logic [RANK_BITS-1:0] hit_rank_q;
	logic                 free_found_q;
	logic [IDX_BITS-1:0]  free_slot_q;
	logic [IDX_BITS-1:0]  lru_slot_q;

	// Update decision
	logic [IDX_BITS-1:0] slot_q;
	logic [CNT_BITS-1:0] limit_q;
	logic                evict_q;

	// Occupancy
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_BITS-1:0] fill_q;
	logic                full;

	// Memory ports
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic [RANK_BITS-1:0]  rank_rd;
	logic                  rank_we;
	logic [RANK_BITS-1:0]  rank_wdata;
	logic                  entry_we;
	logic                  key_we;
	logic                  accept;
	logic                  cur_valid;

	assign accept    = start && !busy;
	assign full      = (fill_q == CNT_BITS'(CAPACITY));
	assign issue     = (cnt_q != CNT_BITS'(CAPACITY));
	assign cur_valid = valid_q[idx_s1];

	// Entry memories
	lrukv_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_BITS), .ADDR_BITS(IDX_BITS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_q),
		.wdata (key_q),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (key_rd)
	);

	lrukv_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS), .ADDR_BITS(IDX_BITS)) u_val_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (slot_q),
		.wdata (val_q),
		.raddr (hit_slot_q),
		.rdata (val_rd)
	);

	lrukv_ram #(.DEPTH(CAPACITY), .WIDTH(RANK_BITS), .ADDR_BITS(IDX_BITS)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wdata),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (rank_rd)
	);

	// Age entries more recent than the limit, zero the touched slot
	always_comb begin
		rank_we    = 1'b0;
		rank_wdata = '0;
		if (state_q == lrukv_pkg::ST_RANK && v_s1) begin
			if (idx_s1 == slot_q) begin
				rank_we    = 1'b1;
				rank_wdata = '0;
			end else if (cur_valid && (CNT_BITS'(rank_rd) < limit_q)) begin
				rank_we    = 1'b1;
				rank_wdata = rank_rd + RANK_BITS'(1);
			end
		end
	end

	// Store key and value at the end of a put
	assign entry_we = (state_q == lrukv_pkg::ST_WRITE) && (func_q == lrukv_pkg::FUNC_PUT);
	assign key_we   = entry_we && !hit_q;

	// Next state and handshake outputs
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			lrukv_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = lrukv_pkg::ST_SCAN;
				end
			end
			lrukv_pkg::ST_SCAN: begin
				if (!issue) begin
					state_d = lrukv_pkg::ST_DECIDE;
				end
			end
			lrukv_pkg::ST_DECIDE: begin
				if (func_q == lrukv_pkg::FUNC_GET && !hit_q) begin
					state_d = lrukv_pkg::ST_DONE;
				end else begin
					state_d = lrukv_pkg::ST_RANK;
				end
			end
			lrukv_pkg::ST_RANK: begin
				if (!issue) begin
					state_d = lrukv_pkg::ST_WRITE;
				end
			end
			lrukv_pkg::ST_WRITE: begin
				state_d = lrukv_pkg::ST_DONE;
			end
			lrukv_pkg::ST_DONE: begin
				busy = 1'b0;
				done = 1'b1;
				state_d = start ? lrukv_pkg::ST_SCAN : lrukv_pkg::ST_IDLE;
			end
			default: begin
				state_d = lrukv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrukv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the command on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			key_q  <= KEY_BITS'($unsigned(cmd.lookup_key));
			val_q  <= VALUE_BITS'($unsigned(cmd.write_value));
		end
	end

	// Advance the entry walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept || state_q == lrukv_pkg::ST_DECIDE) begin
				cnt_q <= '0;
			end else if ((state_q == lrukv_pkg::ST_SCAN || state_q == lrukv_pkg::ST_RANK)
				&& issue) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			v_s1 <= (state_q == lrukv_pkg::ST_SCAN || state_q == lrukv_pkg::ST_RANK) && issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_BITS-1:0];
	end

	// Compare one stored entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == lrukv_pkg::ST_SCAN && v_s1) begin
			if (cur_valid && key_rd == key_q && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lrukv_pkg::ST_SCAN && v_s1) begin
			if (cur_valid && key_rd == key_q && !hit_q) begin
				hit_slot_q <= idx_s1;
				hit_rank_q <= rank_rd;
			end
			if (!cur_valid && !free_found_q) begin
				free_slot_q <= idx_s1;
			end
			if (cur_valid && rank_rd == RANK_BITS'(CAPACITY - 1)) begin
				lru_slot_q <= idx_s1;
			end
		end
	end

	// Pick the slot to touch and the rank limit for aging
	always_ff @(posedge clk) begin
		if (state_q == lrukv_pkg::ST_DECIDE) begin
			if (hit_q) begin
				slot_q  <= hit_slot_q;
				limit_q <= CNT_BITS'(hit_rank_q);
				evict_q <= 1'b0;
			end else if (full) begin
				slot_q  <= lru_slot_q;
				limit_q <= CNT_BITS'(CAPACITY - 1);
				evict_q <= (func_q == lrukv_pkg::FUNC_PUT);
			end else begin
				slot_q  <= free_slot_q;
				limit_q <= CNT_BITS'(CAPACITY);
				evict_q <= 1'b0;
			end
		end
	end

	// Claim a free slot on insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (key_we && !evict_q) begin
			valid_q[slot_q] <= 1'b1;
			fill_q          <= fill_q + CNT_BITS'(1);
		end
	end

	// Drive the result fields
	always_comb begin
		result.found      = hit_q;
		result.read_value = (func_q == lrukv_pkg::FUNC_GET && hit_q) ? 32'(val_rd) : '0;
		result.evicted    = evict_q;
	end

endmodule

@@ rtl/lrukv_ram.sv @@
// Simple dual-port entry memory: one write port, one read port with registered data.
module lrukv_ram #(
	parameter int DEPTH     = lrukv_pkg::DEF_CAPACITY,
	parameter int WIDTH     = lrukv_pkg::DEF_KEY_BITS,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
